>>> hw/rtl/lmcsd_pkg.sv
package lmcsd_pkg;

	localparam int DEF_NUM_COLUMNS     = 8;
	localparam int DEF_NUM_ROWS        = 8;
	localparam int DEF_DRIVER_CHANNELS = 24;

	localparam int GS_BITS  = 12;
	localparam int GS_POS_W = 4;

	localparam int          HOLD_W     = 16;
	localparam logic [15:0] HOLD_RESET = 16'd250;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 1'd1;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_PIXEL = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] KIND_GREEN = 2'd0;
	localparam logic [1:0] KIND_RED   = 2'd1;
	localparam logic [1:0] KIND_BLUE  = 2'd2;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 16;

endpackage

>>> hw/rtl/led_matrix_column_scan_driver.sv
// result path: a tick item's result item is registered in stage one (frame read) and then in the output stage
// throughput: one item per cycle while the output is not stalled, pixel writes and clears included
// the frame store is a synchronous memory read in the stage ahead of the output stage
// reset: scan idle at column 0, scan_enable 0, hold_ticks 250, frame store
// reads as zero through per-pixel valid bits that reset and clear drop at once
module led_matrix_column_scan_driver
	import lmcsd_pkg::*;
#(
	parameter int NUM_COLUMNS     = DEF_NUM_COLUMNS,
	parameter int NUM_ROWS        = DEF_NUM_ROWS,
	parameter int DRIVER_CHANNELS = DEF_DRIVER_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// pixel_x, pixel_y, red_level, green_level, blue_level
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// action
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// column_address, blank_out, enable_out, serial_bit, shift_strobe, latch_pulse, zero pad
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
	localparam int ROW_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int ADDR_W  = COL_W + ROW_W;
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int CH_ROWS = (DRIVER_CHANNELS - 1) / 3 + 1;
	localparam int RCH_W   = (CH_ROWS > 1) ? $clog2(CH_ROWS) : 1;
	localparam logic [RCH_W-1:0]    ROW_INIT  = RCH_W'((DRIVER_CHANNELS - 1) / 3);
	localparam logic [1:0]          KIND_INIT = 2'((DRIVER_CHANNELS - 1) % 3);
	localparam logic [GS_POS_W-1:0] POS_INIT  = GS_POS_W'(GS_BITS - 1);
	localparam logic [COL_W-1:0]    COL_LAST  = COL_W'(NUM_COLUMNS - 1);
	localparam logic [RCH_W:0]      ROW_LIMIT = (RCH_W + 1)'(NUM_ROWS);
	localparam int WORD_W = 3 * GS_BITS;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SHIFT,
		PH_LATCH,
		PH_HOLD
	} phase_t;

	typedef struct packed {
		logic [3:0]          addr;
		logic                blank;
		logic                en;
		logic                strobe;
		logic                latch;
		logic [GS_POS_W-1:0] pos;
		logic [1:0]          kind;
		logic                live;
	} tick_t;

	logic [3:0]  pix_x;
	logic [3:0]  pix_y;
	logic [11:0] red_in;
	logic [11:0] green_in;
	logic [11:0] blue_in;

	logic adv_out;
	logic acc;
	logic tick_acc;
	logic pix_ok;

	logic        scan_en_q;
	logic [15:0] hold_ticks_q;

	phase_t              phase_q, phase_n;
	logic [COL_W-1:0]    col_q, col_n;
	logic [GS_POS_W-1:0] pos_q, pos_n;
	logic [1:0]          kind_q, kind_n;
	logic [RCH_W-1:0]    row_q, row_n;
	logic [HOLD_W-1:0]   hold_q, hold_n;
	phase_t              eff_phase;
	tick_t               tick;

	logic [WORD_W-1:0] frame_mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;

	logic              s1_valid_q;
	tick_t             tick_s1;
	logic [WORD_W-1:0] rd_s1;
	logic [11:0]       level;
	logic              sbit;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	assign pix_x    = s_tdata[3:0];
	assign pix_y    = s_tdata[7:4];
	assign red_in   = s_tdata[19:8];
	assign green_in = s_tdata[35:24];
	assign blue_in  = s_tdata[51:40];

	assign adv_out  = !m_tvalid_q || m_tready;
	assign s_tready = !s1_valid_q || adv_out;
	assign acc      = s_tvalid && s_tready;
	assign tick_acc = acc && (s_tuser == ACT_TICK);
	assign pix_ok   = ({1'b0, pix_x} < 5'(NUM_COLUMNS)) && ({1'b0, pix_y} < 5'(NUM_ROWS));
	assign waddr    = {pix_x[COL_W-1:0], pix_y[ROW_W-1:0]};
	assign raddr    = {col_q, row_q[ROW_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_q    <= 1'b0;
			hold_ticks_q <= HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCAN_ENABLE: scan_en_q    <= cfg_data[0];
				REG_HOLD_TICKS:  hold_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_phase = ((phase_q == PH_IDLE) && scan_en_q) ? PH_SHIFT : phase_q;
		phase_n = eff_phase;
		col_n   = col_q;
		pos_n   = pos_q;
		kind_n  = kind_q;
		row_n   = row_q;
		hold_n  = hold_q;
		tick.addr   = 4'(col_q);
		tick.blank  = 1'b1;
		tick.en     = 1'b0;
		tick.strobe = 1'b0;
		tick.latch  = 1'b0;
		tick.pos    = pos_q;
		tick.kind   = kind_q;
		tick.live   = vld_q[raddr] && ({1'b0, row_q} < ROW_LIMIT);
		case (eff_phase)
			PH_SHIFT: begin
				tick.en     = 1'b1;
				tick.strobe = 1'b1;
				if (pos_q == '0) begin
					pos_n = POS_INIT;
					if ((row_q == '0) && (kind_q == KIND_GREEN)) begin
						phase_n = PH_LATCH;
						row_n   = ROW_INIT;
						kind_n  = KIND_INIT;
					end else if (kind_q == KIND_GREEN) begin
						kind_n = KIND_BLUE;
						row_n  = row_q - 1'b1;
					end else begin
						kind_n = kind_q - 1'b1;
					end
				end else begin
					pos_n = pos_q - 1'b1;
				end
			end
			PH_LATCH: begin
				tick.en    = 1'b1;
				tick.latch = 1'b1;
				hold_n     = '0;
				phase_n    = PH_HOLD;
			end
			PH_HOLD: begin
				tick.blank = 1'b0;
				hold_n     = hold_q + 1'b1;
			end
			default: ;
		endcase
		if (((eff_phase == PH_LATCH) && (hold_ticks_q == '0)) ||
		    ((eff_phase == PH_HOLD) && (({1'b0, hold_q} + 17'd1) >= {1'b0, hold_ticks_q}))) begin
			hold_n = '0;
			pos_n  = POS_INIT;
			kind_n = KIND_INIT;
			row_n  = ROW_INIT;
			if (scan_en_q) begin
				col_n   = (col_q == COL_LAST) ? '0 : col_q + 1'b1;
				phase_n = PH_SHIFT;
			end else begin
				col_n   = '0;
				phase_n = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			col_q      <= '0;
			pos_q      <= POS_INIT;
			kind_q     <= KIND_INIT;
			row_q      <= ROW_INIT;
			hold_q     <= '0;
			s1_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (tick_acc) begin
				phase_q <= phase_n;
				col_q   <= col_n;
				pos_q   <= pos_n;
				kind_q  <= kind_n;
				row_q   <= row_n;
				hold_q  <= hold_n;
			end
			if (tick_acc) begin
				s1_valid_q <= 1'b1;
			end else if (adv_out) begin
				s1_valid_q <= 1'b0;
			end
			if (adv_out) begin
				m_tvalid_q <= s1_valid_q;
				if (s1_valid_q) begin
					m_tdata_q <= {7'd0, tick_s1.latch, tick_s1.strobe, sbit, tick_s1.en,
						tick_s1.blank, tick_s1.addr};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (acc && (s_tuser == ACT_CLEAR)) begin
			vld_q <= '0;
		end else if (acc && (s_tuser == ACT_PIXEL) && pix_ok) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (s_tuser == ACT_PIXEL) && pix_ok) begin
			frame_mem[waddr] <= {blue_in, green_in, red_in};
		end
		if (tick_acc) begin
			rd_s1   <= frame_mem[raddr];
			tick_s1 <= tick;
		end
	end

	always_comb begin
		case (tick_s1.kind)
			KIND_GREEN: level = rd_s1[23:12];
			KIND_RED:   level = rd_s1[11:0];
			KIND_BLUE:  level = rd_s1[35:24];
			default:    level = '0;
		endcase
		sbit = tick_s1.strobe && tick_s1.live && level[tick_s1.pos];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> hw/rtl/lmcsd_checker.sv
module lmcsd_checker
	import lmcsd_pkg::*;
#(
	parameter int NUM_COLUMNS = DEF_NUM_COLUMNS
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	a_bit_needs_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> m_tdata[7])
		else $error("serial bit set without shift strobe");

	a_enable_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5] || m_tdata[7] || m_tdata[8]) |-> m_tdata[4] && m_tdata[5])
		else $error("shift or latch without blank and enable");

	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, m_tdata[3:0]} < 5'(NUM_COLUMNS)))
		else $error("column address out of range");

endmodule

bind led_matrix_column_scan_driver lmcsd_checker #(
	.NUM_COLUMNS(NUM_COLUMNS)
) u_lmcsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
